[sv/mio_pkg.sv]
package mio_pkg;

    // Table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W  = 4;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [1:0]        cmd_t;
    typedef logic [2:0]        status_t;
    typedef logic [1:0]        asize_t;

    // Command codes
    localparam cmd_t CMD_ADD    = 2'd0;
    localparam cmd_t CMD_DEL    = 2'd1;
    localparam cmd_t CMD_LOOKUP = 2'd2;

    // Access size codes
    localparam asize_t SZ_BYTE = 2'd0;
    localparam asize_t SZ_WORD = 2'd1;

    // Result status codes
    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_DUP     = 3'd1;
    localparam status_t ST_FULL    = 3'd2;
    localparam status_t ST_NOTFND  = 3'd3;
    localparam status_t ST_UNKNOWN = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture the request word
        logic compare;  // register match and free vectors
        logic commit;   // update table, load result register
    } mio_ctl_t;

    // Priority encoder result
    typedef struct packed {
        logic found;
        idx_t idx;
    } pick_t;

    // Lowest set bit wins
    function automatic pick_t first_set(input logic [ENTRIES-1:0] vec);
        pick_t p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (vec[i])
            begin
                p.found = 1'b1;
                p.idx   = IDX_W'(i);
            end
        end
        return p;
    endfunction

    // Lookup mask from access width; size three acts as dword
    function automatic logic [31:0] size_mask(input asize_t sz);
        logic [31:0] m;
        case (sz)
            SZ_BYTE: m = 32'h0000_00FF;
            SZ_WORD: m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

[sv/mio_req_if.sv]
interface mio_req_if;
    import mio_pkg::*;

    logic        valid;
    logic        ready;
    cmd_t        cmd;
    logic [15:0] port;
    logic        is_in;
    logic [31:0] match_mask;
    logic [31:0] match_data;
    asize_t      access_size;
    logic [31:0] event_tag;

    modport source (output valid, cmd, port, is_in, match_mask, match_data,
                    access_size, event_tag, input ready);
    modport sink   (input valid, cmd, port, is_in, match_mask, match_data,
                    access_size, event_tag, output ready);
endinterface

[sv/mio_rsp_if.sv]
interface mio_rsp_if;
    import mio_pkg::*;

    logic        valid;
    logic        ready;
    status_t     status;
    logic        hit;
    logic [31:0] hit_tag;
    slot_t       slot;

    modport source (output valid, status, hit, hit_tag, slot, input ready);
    modport sink   (input valid, status, hit, hit_tag, slot, output ready);
endinterface

[sv/mio_ctrl.sv]
module mio_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output mio_pkg::mio_ctl_t  ctl
);
    import mio_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_RES  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   take, commit;

    assign take   = (state_reg == S_IDLE) && req_valid;
    // result register must be free or draining this cycle
    assign commit = (state_reg == S_RES) && (!out_valid_reg || rsp_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (req_valid) state_next = S_CMP;
            S_CMP:   state_next = S_RES;
            S_RES:   if (commit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Output word valid
    always_comb
    begin
        if (commit)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready   = (state_reg == S_IDLE);
    assign rsp_valid   = out_valid_reg;
    assign ctl.load    = take;
    assign ctl.compare = (state_reg == S_CMP);
    assign ctl.commit  = commit;

endmodule

[sv/mio_dpath.sv]
module mio_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  mio_pkg::mio_ctl_t  ctl,
    input  mio_pkg::cmd_t      cmd,
    input  logic [15:0]        port,
    input  logic               is_in,
    input  logic [31:0]        match_mask,
    input  logic [31:0]        match_data,
    input  mio_pkg::asize_t    access_size,
    input  logic [31:0]        event_tag,
    output mio_pkg::status_t   status,
    output logic               hit,
    output logic [31:0]        hit_tag,
    output mio_pkg::slot_t     slot
);
    import mio_pkg::*;

    // Request word
    cmd_t        q_cmd_reg;
    logic [15:0] q_port_reg;
    logic        q_dir_reg;
    logic [31:0] q_mask_reg;
    logic [31:0] q_data_reg;
    logic [31:0] q_tag_reg;

    // Table
    logic        ent_valid_reg [ENTRIES];
    logic [15:0] ent_port_reg  [ENTRIES];
    logic        ent_dir_reg   [ENTRIES];
    logic [31:0] ent_mask_reg  [ENTRIES];
    logic [31:0] ent_data_reg  [ENTRIES];
    logic [31:0] ent_tag_reg   [ENTRIES];

    logic [ENTRIES-1:0] match_next, match_reg;
    logic [ENTRIES-1:0] free_next, free_reg;

    // Result word
    status_t     status_reg, status_next;
    logic        hit_reg, hit_next;
    logic [31:0] tag_reg, tag_next;
    slot_t       slot_reg, slot_next;

    pick_t m_pick, f_pick;
    logic  do_add, do_del;

    // Capture request; lookups take their mask from the access width
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            q_cmd_reg  <= cmd;
            q_port_reg <= port;
            q_dir_reg  <= is_in;
            q_mask_reg <= (cmd == CMD_LOOKUP) ? size_mask(access_size) : match_mask;
            q_data_reg <= match_data;
            q_tag_reg  <= event_tag;
        end
    end

    // Parallel masked compare, one lane per entry
    always_comb
    begin
        logic [31:0] k;
        for (int i = 0; i < ENTRIES; i++)
        begin
            k = ent_mask_reg[i] & q_mask_reg;
            match_next[i] = ent_valid_reg[i] && (ent_port_reg[i] == q_port_reg)
                            && (ent_dir_reg[i] == q_dir_reg)
                            && ((k & ent_data_reg[i]) == (k & q_data_reg));
            free_next[i]  = !ent_valid_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.compare)
        begin
            match_reg <= match_next;
            free_reg  <= free_next;
        end
    end

    // Resolve: priority pick and result word
    always_comb
    begin
        m_pick      = first_set(match_reg);
        f_pick      = first_set(free_reg);
        do_add      = 1'b0;
        do_del      = 1'b0;
        status_next = ST_OK;
        hit_next    = 1'b0;
        tag_next    = '0;
        slot_next   = '0;
        case (q_cmd_reg)
            CMD_ADD:
            begin
                if (m_pick.found)
                begin
                    status_next = ST_DUP;
                    slot_next   = slot_t'(m_pick.idx);
                end
                else if (!f_pick.found)
                    status_next = ST_FULL;
                else
                begin
                    do_add    = 1'b1;
                    slot_next = slot_t'(f_pick.idx);
                end
            end
            CMD_DEL:
            begin
                if (m_pick.found)
                begin
                    do_del    = 1'b1;
                    slot_next = slot_t'(m_pick.idx);
                end
                else
                    status_next = ST_NOTFND;
            end
            CMD_LOOKUP:
            begin
                if (m_pick.found)
                begin
                    hit_next  = 1'b1;
                    tag_next  = ent_tag_reg[m_pick.idx];
                    slot_next = slot_t'(m_pick.idx);
                end
            end
            default: status_next = ST_UNKNOWN;
        endcase
    end

    // Valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                ent_valid_reg[i] <= 1'b0;
        end
        else if (ctl.commit)
        begin
            if (do_add)
                ent_valid_reg[f_pick.idx] <= 1'b1;
            else if (do_del)
                ent_valid_reg[m_pick.idx] <= 1'b0;
        end
    end

    // Entry payload, written on add
    always_ff @(posedge clk)
    begin
        if (ctl.commit && do_add)
        begin
            ent_port_reg[f_pick.idx] <= q_port_reg;
            ent_dir_reg[f_pick.idx]  <= q_dir_reg;
            ent_mask_reg[f_pick.idx] <= q_mask_reg;
            ent_data_reg[f_pick.idx] <= q_data_reg;
            ent_tag_reg[f_pick.idx]  <= q_tag_reg;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            status_reg <= status_next;
            hit_reg    <= hit_next;
            tag_reg    <= tag_next;
            slot_reg   <= slot_next;
        end
    end

    assign status  = status_reg;
    assign hit     = hit_reg;
    assign hit_tag = tag_reg;
    assign slot    = slot_reg;

endmodule

[sv/masked_io_match_table.sv]
// Channel  Dir  Word
// -------  ---  ------------------------------------------------------------
// req      in   cmd, port, is_in, match_mask, match_data, access_size, event_tag
// rsp      out  status, hit, hit_tag, slot
//
// Each command runs three steps: capture, parallel compare of all entries
// into a match vector, then priority pick with table update and result load.
// A new command is taken as soon as the previous one has loaded its result;
// a result held by a stalled rsp only delays the pick cycle of the next one.
// Reset clears the valid marks and the control state; entry contents are
// written on add and never cleared.
module masked_io_match_table (
    input  logic       clk,
    input  logic       rst_n,
    mio_req_if.sink    req,
    mio_rsp_if.source  rsp
);
    import mio_pkg::*;

    mio_ctl_t ctl;

    mio_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl)
    );

    mio_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cmd         (req.cmd),
        .port        (req.port),
        .is_in       (req.is_in),
        .match_mask  (req.match_mask),
        .match_data  (req.match_data),
        .access_size (req.access_size),
        .event_tag   (req.event_tag),
        .status      (rsp.status),
        .hit         (rsp.hit),
        .hit_tag     (rsp.hit_tag),
        .slot        (rsp.slot)
    );

endmodule

[sv/mio_checker.sv]
module mio_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input mio_pkg::status_t  rsp_status,
    input logic              rsp_hit,
    input logic [31:0]       rsp_hit_tag
);
    import mio_pkg::*;

    // A held result word stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp word dropped while stalled");

    // One command in flight at a time
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req taken while a command is in flight");

    // Every accepted command has a result offered once it has passed the compare and result states
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> ##3 rsp_valid)
        else $error("rsp word missing after command");

    // A hit only comes with ok status
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_hit |-> rsp_status == ST_OK)
        else $error("hit with non-ok status");

    // No tag without a hit
    a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_hit_tag == 32'd0)
        else $error("hit_tag set on a miss");

endmodule

bind masked_io_match_table mio_checker u_mio_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_status  (rsp.status),
    .rsp_hit     (rsp.hit),
    .rsp_hit_tag (rsp.hit_tag)
);

[dv/masked_io_match_table_tb.sv]
module masked_io_match_table_tb;
    import mio_pkg::*;

    // Codes the package leaves unnamed
    localparam cmd_t   CMD_BAD  = 2'd3;
    localparam asize_t SZ_DWORD = 2'd2;
    localparam asize_t SZ_WIDE  = 2'd3;   // reserved width, acts as dword

    localparam int RAND_WORDS   = 1250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int KEY_POOL_MAX = 24;

    typedef struct {
        cmd_t        cmd;
        logic [15:0] port;
        logic        is_in;
        logic [31:0] mask;
        logic [31:0] data;
        asize_t      size;
        logic [31:0] tag;
    } req_word_t;

    typedef struct {
        status_t     status;
        logic        hit;
        logic [31:0] hit_tag;
        slot_t       slot;
    } rsp_word_t;

    logic clk = 1'b0;
    logic rst_n;

    mio_req_if req_if ();
    mio_rsp_if rsp_if ();

    masked_io_match_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the watch table
    logic        tbl_valid [ENTRIES];
    logic [15:0] tbl_port  [ENTRIES];
    logic        tbl_dir   [ENTRIES];
    logic [31:0] tbl_mask  [ENTRIES];
    logic [31:0] tbl_data  [ENTRIES];
    logic [31:0] tbl_tag   [ENTRIES];

    req_word_t req_backlog [$];
    rsp_word_t rsp_due     [$];
    req_word_t watch_keys  [$];
    req_word_t nxt_word;

    int errors     = 0;
    int n_added    = 0;
    int n_dup      = 0;
    int n_full     = 0;
    int n_removed  = 0;
    int n_notfnd   = 0;
    int n_hits     = 0;
    int n_misses   = 0;
    int n_unknown  = 0;
    int n_checked  = 0;
    int cycles     = 0;
    int burst_left = 1;
    int gap_left   = 0;
    int stall_left = 0;
    int rsp_cyc    = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Lowest valid entry that matches port, direction and data under both masks
    function automatic int table_find(input logic [15:0] p, input logic d,
                                      input logic [31:0] m, input logic [31:0] x);
        logic [31:0] k;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tbl_valid[i] && tbl_port[i] == p && tbl_dir[i] == d)
            begin
                k = tbl_mask[i] & m;
                if ((k & tbl_data[i]) == (k & x))
                    return i;
            end
        end
        return -1;
    endfunction

    // Apply one command to the shadow table and return the result word
    function automatic rsp_word_t table_apply(input req_word_t w);
        rsp_word_t   r;
        int          i;
        int          f;
        logic [31:0] lk_mask;
        r.status  = ST_OK;
        r.hit     = 1'b0;
        r.hit_tag = '0;
        r.slot    = '0;
        case (w.cmd)
            CMD_ADD:
            begin
                i = table_find(w.port, w.is_in, w.mask, w.data);
                if (i >= 0)
                begin
                    r.status = ST_DUP;
                    r.slot   = slot_t'(i);
                    n_dup++;
                end
                else
                begin
                    f = -1;
                    for (int j = ENTRIES - 1; j >= 0; j--)
                        if (!tbl_valid[j])
                            f = j;
                    if (f < 0)
                    begin
                        r.status = ST_FULL;
                        n_full++;
                    end
                    else
                    begin
                        tbl_valid[f] = 1'b1;
                        tbl_port[f]  = w.port;
                        tbl_dir[f]   = w.is_in;
                        tbl_mask[f]  = w.mask;
                        tbl_data[f]  = w.data;
                        tbl_tag[f]   = w.tag;
                        r.slot       = slot_t'(f);
                        n_added++;
                    end
                end
            end
            CMD_DEL:
            begin
                i = table_find(w.port, w.is_in, w.mask, w.data);
                if (i < 0)
                begin
                    r.status = ST_NOTFND;
                    n_notfnd++;
                end
                else
                begin
                    tbl_valid[i] = 1'b0;
                    r.slot       = slot_t'(i);
                    n_removed++;
                end
            end
            CMD_LOOKUP:
            begin
                case (w.size)
                    SZ_BYTE: lk_mask = 32'h0000_00FF;
                    SZ_WORD: lk_mask = 32'h0000_FFFF;
                    default: lk_mask = 32'hFFFF_FFFF;
                endcase
                i = table_find(w.port, w.is_in, lk_mask, w.data);
                if (i >= 0)
                begin
                    r.hit     = 1'b1;
                    r.hit_tag = tbl_tag[i];
                    r.slot    = slot_t'(i);
                    n_hits++;
                end
                else
                    n_misses++;
            end
            default:
            begin
                r.status = ST_UNKNOWN;
                n_unknown++;
            end
        endcase
        return r;
    endfunction

    function automatic void queue_cmd(input cmd_t c, input logic [15:0] p, input logic d,
                                      input logic [31:0] m, input logic [31:0] x,
                                      input asize_t s, input logic [31:0] t);
        req_word_t w;
        w.cmd   = c;
        w.port  = p;
        w.is_in = d;
        w.mask  = m;
        w.data  = x;
        w.size  = s;
        w.tag   = t;
        req_backlog.push_back(w);
    endfunction

    // Mostly a handful of busy ports so entries collide
    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'h0060;
            4, 5: return 16'h0064;
            6, 7: return 16'h03F8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_mask();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_00FF;
            3: return 32'hFFFF_0000;
            default: return $urandom;
        endcase
    endfunction

    // Driver: bursts of words separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_if.valid <= 1'b0;
        else if (!req_if.valid || req_if.ready)
        begin
            // word on the bus was taken at this edge
            if (req_if.valid)
            begin
                nxt_word.cmd   = req_if.cmd;
                nxt_word.port  = req_if.port;
                nxt_word.is_in = req_if.is_in;
                nxt_word.mask  = req_if.match_mask;
                nxt_word.data  = req_if.match_data;
                nxt_word.size  = req_if.access_size;
                nxt_word.tag   = req_if.event_tag;
                rsp_due.push_back(table_apply(nxt_word));
            end
            if (gap_left > 0)
            begin
                gap_left--;
                req_if.valid <= 1'b0;
            end
            else if (req_backlog.size() > 0)
            begin
                nxt_word = req_backlog.pop_front();
                req_if.cmd         <= nxt_word.cmd;
                req_if.port        <= nxt_word.port;
                req_if.is_in       <= nxt_word.is_in;
                req_if.match_mask  <= nxt_word.mask;
                req_if.match_data  <= nxt_word.data;
                req_if.access_size <= nxt_word.size;
                req_if.event_tag   <= nxt_word.tag;
                req_if.valid       <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // Compare one result word against the oldest expectation
    task automatic check_rsp();
        rsp_word_t want;
        n_checked++;
        if (rsp_due.size() == 0)
        begin
            $display("%0t: unexpected result word: status %0d hit %0b tag %h slot %0d",
                     $time, rsp_if.status, rsp_if.hit, rsp_if.hit_tag, rsp_if.slot);
            errors++;
        end
        else
        begin
            want = rsp_due.pop_front();
            if (rsp_if.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, rsp_if.status);
                errors++;
            end
            if (rsp_if.hit !== want.hit)
            begin
                $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_if.hit);
                errors++;
            end
            if (rsp_if.hit_tag !== want.hit_tag)
            begin
                $display("%0t: hit_tag expected %h actual %h",
                         $time, want.hit_tag, rsp_if.hit_tag);
                errors++;
            end
            if (rsp_if.slot !== want.slot)
            begin
                $display("%0t: slot expected %0d actual %0d", $time, want.slot, rsp_if.slot);
                errors++;
            end
        end
    endtask

    // Monitor: checks results; ready rotates through always high, random, a periodic pattern and random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
                check_rsp();
            rsp_cyc++;
            case ((rsp_cyc / 160) % 4)
                0: rsp_if.ready <= 1'b1;
                1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
                2: rsp_if.ready <= (rsp_cyc % 3 == 0);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        rsp_if.ready <= 1'b0;
                    end
                    else
                    begin
                        rsp_if.ready <= 1'b1;
                        if ($urandom_range(0, 5) == 0)
                            stall_left = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still due", $time, rsp_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        req_word_t   k;
        int          idx;
        int          roll;
        int          add_share;
        int          del_share;
        logic [31:0] x;

        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.cmd          = CMD_ADD;
        req_if.port         = '0;
        req_if.is_in        = 1'b0;
        req_if.match_mask   = '0;
        req_if.match_data   = '0;
        req_if.access_size  = SZ_BYTE;
        req_if.event_tag    = '0;
        rsp_if.ready        = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            tbl_valid[i] = 1'b0;

        // Directed: empty table, extremes, duplicates, mask zero, lookup widths
        queue_cmd(CMD_LOOKUP, 16'h0000, 1'b0, '0, '0, SZ_BYTE, '0);
        queue_cmd(CMD_DEL, 16'h0000, 1'b0, '0, '0, SZ_BYTE, '0);
        queue_cmd(CMD_BAD, 16'hFFFF, 1'b1, '1, '1, SZ_WIDE, '1);
        queue_cmd(CMD_ADD, 16'hFFFF, 1'b1, '1, '1, SZ_WIDE, '1);
        queue_cmd(CMD_ADD, 16'hFFFF, 1'b1, '1, '1, SZ_BYTE, 32'h1234_5678);
        queue_cmd(CMD_ADD, 16'h0000, 1'b0, '0, '0, SZ_BYTE, '0);
        queue_cmd(CMD_ADD, 16'h0000, 1'b0, 32'h0000_00FF, 32'h0000_0012, SZ_BYTE, '1);
        queue_cmd(CMD_ADD, 16'h0000, 1'b1, 32'h0000_FF00, 32'h0000_3400, SZ_BYTE,
                  32'hA5A5_5A5A);
        queue_cmd(CMD_LOOKUP, 16'h0000, 1'b1, '0, 32'h0000_0000, SZ_BYTE, '0);
        queue_cmd(CMD_LOOKUP, 16'h0000, 1'b1, '0, 32'h0000_3500, SZ_WORD, '0);
        queue_cmd(CMD_LOOKUP, 16'h0000, 1'b1, '0, 32'hFFFF_3401, SZ_WIDE, '0);
        queue_cmd(CMD_LOOKUP, 16'h0000, 1'b1, '0, 32'hABCD_3400, SZ_DWORD, '0);
        queue_cmd(CMD_DEL, 16'hFFFF, 1'b1, '1, '1, SZ_BYTE, '0);
        // fill all free slots but one, then one more add takes the last free slot
        for (int i = 0; i < ENTRIES - 3; i++)
            queue_cmd(CMD_ADD, 16'h0100 + 16'(i), 1'($urandom), '1, $urandom, SZ_BYTE,
                      $urandom);
        queue_cmd(CMD_ADD, 16'h0200, 1'b0, '1, '0, SZ_BYTE, '0);

        // Random: phases lean toward adds or deletes so the table fills and drains
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            add_share = ((n / 100) % 2 == 0) ? 45 : 20;
            del_share = ((n / 100) % 2 == 0) ? 15 : 40;
            roll = $urandom_range(0, 99);
            if (roll < add_share)
            begin
                k.cmd   = CMD_ADD;
                k.port  = pick_port();
                k.is_in = 1'($urandom);
                k.mask  = pick_mask();
                k.data  = $urandom;
                k.size  = 2'($urandom);
                k.tag   = $urandom;
                req_backlog.push_back(k);
                watch_keys.push_back(k);
                if (watch_keys.size() > KEY_POOL_MAX)
                    void'(watch_keys.pop_front());
            end
            else if (roll < add_share + del_share)
            begin
                if (watch_keys.size() > 0 && $urandom_range(0, 9) < 7)
                begin
                    idx = $urandom_range(0, watch_keys.size() - 1);
                    k = watch_keys[idx];
                    watch_keys.delete(idx);
                    // bits outside the stored mask do not matter
                    x = k.data ^ ($urandom & ~k.mask);
                    queue_cmd(CMD_DEL, k.port, k.is_in, k.mask, x, 2'($urandom), $urandom);
                end
                else
                    queue_cmd(CMD_DEL, pick_port(), 1'($urandom), pick_mask(), $urandom,
                              2'($urandom), $urandom);
            end
            else if (roll < 93)
            begin
                if (watch_keys.size() > 0 && $urandom_range(0, 9) < 7)
                begin
                    k = watch_keys[$urandom_range(0, watch_keys.size() - 1)];
                    x = k.data ^ ($urandom & ~k.mask);
                    if ($urandom_range(0, 4) == 0)
                        x = x ^ (32'h1 << $urandom_range(0, 31));
                    queue_cmd(CMD_LOOKUP, k.port, k.is_in, $urandom, x, 2'($urandom),
                              $urandom);
                end
                else
                    queue_cmd(CMD_LOOKUP, pick_port(), 1'($urandom), $urandom, $urandom,
                              2'($urandom), $urandom);
            end
            else if (roll < 96)
                queue_cmd(CMD_BAD, pick_port(), 1'($urandom), $urandom, $urandom,
                          2'($urandom), $urandom);
            else
                // noise: every field fully random
                queue_cmd(cmd_t'($urandom), 16'($urandom), 1'($urandom), $urandom,
                          $urandom, 2'($urandom), $urandom);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: all words sent, all results back, then idle before the summary
        while (req_backlog.size() != 0 || req_if.valid || rsp_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d result words: %0d adds placed, %0d duplicates, %0d table full",
                 n_checked, n_added, n_dup, n_full);
        $display("  %0d deletes done, %0d not found, %0d lookup hits, %0d misses, %0d bad cmds",
                 n_removed, n_notfnd, n_hits, n_misses, n_unknown);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
sv/mio_pkg.sv
sv/mio_req_if.sv
sv/mio_rsp_if.sv
sv/mio_ctrl.sv
sv/mio_dpath.sv
sv/masked_io_match_table.sv
sv/mio_checker.sv
dv/masked_io_match_table_tb.sv
